/* sv/tsd_pkg.sv */
// ----------------------------------------------------------------------------
// tsd_pkg
// Shared types, constants and helper functions of the scratchpad decoder.
// ----------------------------------------------------------------------------
package tsd_pkg;

    localparam int unsigned FRAME_LEN     = 9;
    localparam int unsigned QUEUE_DEPTH   = 2;
    localparam int unsigned IDX_W         = 4;

    localparam logic [7:0]  CRC_POLY_REFL = 8'h8C;
    localparam logic [7:0]  NO_DATA_RESET = 8'h80;
    localparam logic [6:0]  HALF_DEG_FRACT = 7'd50;

    // byte positions inside a frame
    localparam logic [IDX_W-1:0] IDX_TEMP_LOW  = IDX_W'(0);
    localparam logic [IDX_W-1:0] IDX_TEMP_HIGH = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_CRC       = IDX_W'(FRAME_LEN - 1);
    localparam logic [IDX_W-1:0] IDX_DONE      = IDX_W'(FRAME_LEN);

    typedef logic [0:0] cfg_index_t;
    localparam cfg_index_t CFG_SENSOR_TYPE  = 1'b0;
    localparam cfg_index_t CFG_NO_DATA_CODE = 1'b1;

    typedef enum logic
    {
        SENSOR_SIXTEENTH = 1'b0,
        SENSOR_HALF      = 1'b1
    } sensor_type_t;

    typedef struct packed
    {
        sensor_type_t      sensor_type;
        logic signed [7:0] no_data_code;
    } cfg_t;

    // one checked frame handed from front to back
    typedef struct packed
    {
        logic        crc_ok;
        logic [15:0] raw;
    } frame_t;

    function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic       mix;
        c = crc;
        for (int k = 0; k < 8; k++)
        begin
            mix = c[0] ^ b[k];
            c   = {1'b0, c[7:1]};
            if (mix)
            begin
                c = c ^ CRC_POLY_REFL;
            end
        end
        return c;
    endfunction

    // hundredths for a sixteenth-degree nibble: floor(25 * n / 4)
    function automatic logic [6:0] fract_sixteenth(input logic [3:0] n);
        logic [8:0] prod;
        prod = 9'(n) * 9'd25;
        return prod[8:2];
    endfunction

endpackage

/* sv/tsd_if.sv */
// ----------------------------------------------------------------------------
// tsd_if
// Channel interfaces of the scratchpad decoder: byte input, result, config.
// ----------------------------------------------------------------------------
interface tsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;

    modport source (output valid, output data_byte, output first_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

interface tsd_out_if;
    logic               valid;
    logic               ready;
    logic               crc_ok;
    logic               negative;
    logic signed [15:0] whole;
    logic [6:0]         fract;

    modport source (output valid, output crc_ok, output negative, output whole,
                    output fract, input ready);
    modport sink   (input valid, input crc_ok, input negative, input whole,
                    input fract, output ready);
endinterface

interface tsd_cfg_if;
    logic       valid;
    logic       ready;
    logic [0:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/temp_sensor_scratchpad_decode_core.sv */
// ----------------------------------------------------------------------------
// temp_sensor_scratchpad_decode_core
// Scratchpad decoder for a one-wire temperature sensor with CRC-8 check.
// ----------------------------------------------------------------------------
// scratch: one scratchpad byte per item, first_byte marks byte zero and
//   restarts the frame. bytes after the ninth are dropped until the next
//   first_byte. a byte is taken every cycle while the frame queue has room.
// result: one item per frame, sent after the ninth byte. on a CRC match it
//   carries sign, whole degrees and hundredths; on a mismatch it carries the
//   no-data code as whole, fraction 0 and crc_ok 0.
// cfg: index 0 selects sixteenth- or half-degree units, index 1 sets the
//   no-data code. writes are taken every cycle and apply to later results.
// path: the ninth byte queues its record; a pop loads the output register.
// throughput: one byte per cycle, set by the single-byte CRC step in front.
// when the result side stalls the output register holds, the frame queue
//   fills, and scratch.ready drops only once the queue is full.
// reset: frame position, CRC and queue are cleared, units go to sixteenths,
//   the no-data code to -128; the first byte after reset starts a frame.
// ----------------------------------------------------------------------------
module temp_sensor_scratchpad_decode_core
    import tsd_pkg::*;
#(
    parameter int unsigned QDEPTH = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    tsd_in_if.sink     scratch,
    tsd_out_if.source  result,
    tsd_cfg_if.sink    cfg
);

    cfg_t   cfg_reg, cfg_next;
    logic   q_push;
    logic   q_pop;
    logic   q_full;
    logic   q_empty;
    frame_t q_in;
    frame_t q_out;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_SENSOR_TYPE:  cfg_next.sensor_type  = sensor_type_t'(cfg.data[0]);
                CFG_NO_DATA_CODE: cfg_next.no_data_code = signed'(cfg.data);
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{sensor_type: SENSOR_SIXTEENTH, no_data_code: signed'(NO_DATA_RESET)};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tsd_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .scratch (scratch),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_in)
    );

    tsd_queue #(
        .DEPTH (QDEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (q_out)
    );

    tsd_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_data  (q_out),
        .q_pop   (q_pop),
        .result  (result)
    );

endmodule

/* sv/tsd_front.sv */
// ----------------------------------------------------------------------------
// tsd_front
// Takes scratchpad bytes, tracks the frame position, runs the CRC-8 and
// pushes one checked frame record when the ninth byte arrives.
// ----------------------------------------------------------------------------
module tsd_front
    import tsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    tsd_in_if.sink      scratch,
    input  logic        q_full,
    output logic        q_push,
    output frame_t      q_data
);

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       crc_reg, crc_next;
    logic [7:0]       tlow_reg, tlow_next;
    logic [7:0]       thigh_reg, thigh_next;
    logic [IDX_W-1:0] idx_eff;
    logic [7:0]       crc_eff;
    logic             accept;

    assign scratch.ready = !q_full;
    assign accept        = scratch.valid && scratch.ready;

    // a first-byte flag restarts the frame
    assign idx_eff = scratch.first_byte ? IDX_TEMP_LOW : idx_reg;
    assign crc_eff = scratch.first_byte ? 8'h00 : crc_reg;

    always_comb
    begin
        idx_next   = idx_reg;
        crc_next   = crc_reg;
        tlow_next  = tlow_reg;
        thigh_next = thigh_reg;
        q_push     = 1'b0;
        q_data     = '{crc_ok: (scratch.data_byte == crc_eff), raw: {thigh_reg, tlow_reg}};
        if (accept)
        begin
            priority if (idx_eff < IDX_CRC)
            begin
                if (idx_eff == IDX_TEMP_LOW)
                begin
                    tlow_next = scratch.data_byte;
                end
                if (idx_eff == IDX_TEMP_HIGH)
                begin
                    thigh_next = scratch.data_byte;
                end
                crc_next = crc_update(crc_eff, scratch.data_byte);
                idx_next = idx_eff + IDX_W'(1);
            end
            else if (idx_eff == IDX_CRC)
            begin
                q_push   = 1'b1;
                crc_next = crc_eff;
                idx_next = IDX_DONE;
            end
            else
            begin
                // trailing bytes after a finished frame are dropped
                crc_next = crc_eff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            crc_reg   <= '0;
            tlow_reg  <= '0;
            thigh_reg <= '0;
        end
        else
        begin
            idx_reg   <= idx_next;
            crc_reg   <= crc_next;
            tlow_reg  <= tlow_next;
            thigh_reg <= thigh_next;
        end
    end

endmodule

/* sv/tsd_queue.sv */
// ----------------------------------------------------------------------------
// tsd_queue
// Small FIFO of checked frame records between front and back.
// ----------------------------------------------------------------------------
module tsd_queue
    import tsd_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  frame_t push_data,
    output logic   full,
    input  logic   pop,
    output logic   empty,
    output frame_t pop_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    frame_t             mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* sv/tsd_back.sv */
// ----------------------------------------------------------------------------
// tsd_back
// Turns a checked frame into sign, whole degrees and hundredths and holds
// the result in the output register until it is taken.
// ----------------------------------------------------------------------------
module tsd_back
    import tsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       q_empty,
    input  frame_t     q_data,
    output logic       q_pop,
    tsd_out_if.source  result
);

    logic               valid_reg, valid_next;
    logic               crc_ok_reg;
    logic               neg_reg;
    logic signed [15:0] whole_reg;
    logic [6:0]         fract_reg;

    logic               neg;
    logic [15:0]        mag;
    logic signed [15:0] whole_calc;
    logic [6:0]         fract_calc;

    assign q_pop = !q_empty && (!valid_reg || result.ready);

    // raw 0x8000 gives magnitude 0x8000, still fits unsigned
    assign neg = q_data.raw[15];
    assign mag = neg ? (~q_data.raw + 16'd1) : q_data.raw;

    always_comb
    begin
        unique case (cfg.sensor_type)
            SENSOR_SIXTEENTH:
            begin
                whole_calc = signed'({4'b0000, mag[15:4]});
                fract_calc = fract_sixteenth(mag[3:0]);
            end
            SENSOR_HALF:
            begin
                whole_calc = signed'({1'b0, mag[15:1]});
                fract_calc = mag[0] ? HALF_DEG_FRACT : 7'd0;
            end
            default:
            begin
                whole_calc = '0;
                fract_calc = '0;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (q_pop)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            crc_ok_reg <= q_data.crc_ok;
            if (q_data.crc_ok)
            begin
                neg_reg   <= neg;
                whole_reg <= whole_calc;
                fract_reg <= fract_calc;
            end
            else
            begin
                neg_reg   <= 1'b0;
                whole_reg <= 16'(cfg.no_data_code);
                fract_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign result.valid    = valid_reg;
    assign result.crc_ok   = crc_ok_reg;
    assign result.negative = neg_reg;
    assign result.whole    = whole_reg;
    assign result.fract    = fract_reg;

endmodule
